>>> hdl/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// shared constants for the battery grade debouncer
// ----------------------------------------------------------------------------
`default_nettype none

package bgd_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_THR_CRITICAL  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_THR_GRADE1    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_THR_GRADE2    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_THR_GRADE3    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_THR_GRADE4    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM_COUNT = 3'd5;

  // register widths
  localparam int unsigned THR_BITS     = 12;
  localparam int unsigned CONFIRM_BITS = 8;
  localparam int unsigned CFG_DATA_BITS = 12;

  // register reset values
  localparam logic [THR_BITS-1:0]     THR_CRITICAL_RST  = 12'd2867;
  localparam logic [THR_BITS-1:0]     THR_GRADE1_RST    = 12'd2932;
  localparam logic [THR_BITS-1:0]     THR_GRADE2_RST    = 12'd2991;
  localparam logic [THR_BITS-1:0]     THR_GRADE3_RST    = 12'd3058;
  localparam logic [THR_BITS-1:0]     THR_GRADE4_RST    = 12'd3241;
  localparam logic [CONFIRM_BITS-1:0] CONFIRM_COUNT_RST = 8'd10;

  // request types
  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_REGRADE = 2'd1;
  localparam logic [1:0] REQ_INIT    = 2'd2;

  // charge status, also used for the charger phase
  localparam logic [1:0] STAT_NORMAL   = 2'd0;
  localparam logic [1:0] STAT_CHARGING = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  // charge icon
  localparam logic [1:0] ICON_NONE     = 2'd0;
  localparam logic [1:0] ICON_CHARGING = 2'd1;
  localparam logic [1:0] ICON_FULL     = 2'd2;

  // bands: critical, then grades 0..4
  localparam int unsigned NUM_BANDS = 6;
  localparam int unsigned BAND_BITS = 3;
  localparam int unsigned GRADE_BITS = 3;
  localparam logic [GRADE_BITS-1:0] GRADE_RST = 3'd1;

endpackage

`default_nettype wire

>>> hdl/battery_grade_debouncer.sv
// ----------------------------------------------------------------------------
// battery_grade_debouncer
// debounces battery adc samples into a committed grade and tracks charger pins
// ----------------------------------------------------------------------------
// result: registered in the output register, or in the skid entry when the output is stalled
// throughput: one item per cycle while in_stall is low; a two-entry output buffer keeps
//   accepting while one result waits to be taken, and in_stall rises once both entries are full
// reset: thresholds and confirm count to defaults, run counters cleared,
//   grade one, charger state normal, output buffer empty
`default_nettype none

module battery_grade_debouncer #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned RUN_BITS    = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bgd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [bgd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // input items
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           req_type,
  input  wire logic [SAMPLE_BITS-1:0]               sample,
  input  wire logic                                 busy_pin,
  input  wire logic                                 full_pin,
  input  wire logic                                 signed_on,
  input  wire logic                                 shutdown_pending,
  // result items
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [bgd_pkg::GRADE_BITS-1:0]            grade,
  output logic [1:0]                                charge_status,
  output logic [1:0]                                charge_icon,
  output logic                                      low_batt,
  output logic                                      regrade_request,
  output logic                                      shutdown_request,
  output logic                                      sensor_restart,
  output logic                                      sensor_stop
);

  localparam int unsigned CW = (SAMPLE_BITS > bgd_pkg::THR_BITS) ?
                               SAMPLE_BITS : bgd_pkg::THR_BITS;
  localparam int unsigned LW = (RUN_BITS > bgd_pkg::CONFIRM_BITS) ?
                               RUN_BITS : bgd_pkg::CONFIRM_BITS;
  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  typedef struct packed {
    logic [bgd_pkg::GRADE_BITS-1:0] grade;
    logic [1:0]                     status;
    logic [1:0]                     icon;
    logic                           low;
    logic                           regrade;
    logic                           shut;
    logic                           restart;
    logic                           stop;
  } result_t;

  // configuration registers
  logic [bgd_pkg::THR_BITS-1:0]     thr_critical;
  logic [bgd_pkg::THR_BITS-1:0]     thr_grade1;
  logic [bgd_pkg::THR_BITS-1:0]     thr_grade2;
  logic [bgd_pkg::THR_BITS-1:0]     thr_grade3;
  logic [bgd_pkg::THR_BITS-1:0]     thr_grade4;
  logic [bgd_pkg::CONFIRM_BITS-1:0] confirm_count;

  // block state
  logic [RUN_BITS-1:0]            band_runs [bgd_pkg::NUM_BANDS];
  logic [bgd_pkg::GRADE_BITS-1:0] cur_grade;
  logic [1:0]                     chg_phase;
  logic [1:0]                     status_reg;
  logic                           plugged_while_off;
  logic                           low_flag;

  // output buffer
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;

  // next values
  logic [RUN_BITS-1:0]            band_runs_next [bgd_pkg::NUM_BANDS];
  logic [bgd_pkg::GRADE_BITS-1:0] cur_grade_next;
  logic [1:0]                     chg_phase_next;
  logic [1:0]                     status_reg_next;
  logic                           plugged_while_off_next;
  logic                           low_flag_next;
  result_t                        res;

  logic [RUN_BITS-1:0]            run_limit;
  logic [LW-1:0]                  confirm_ext;
  logic [CW-1:0]                  s_ext;
  logic [bgd_pkg::GRADE_BITS-1:0] grade_of;
  logic [bgd_pkg::BAND_BITS-1:0]  band;
  logic                           in_accept;
  logic                           out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid & ~skid_valid;
  assign out_take  = out_valid & ~out_stall;

  // clamp of the confirm count to 1..RUN_MAX
  always_comb begin
    confirm_ext = LW'(confirm_count);
    if (confirm_count == '0) begin
      run_limit = RUN_BITS'(1);
    end else if (confirm_ext > LW'(RUN_MAX)) begin
      run_limit = RUN_MAX;
    end else begin
      run_limit = confirm_ext[RUN_BITS-1:0];
    end
  end

  // band selection
  always_comb begin
    s_ext = CW'(sample);
    if (s_ext < CW'(thr_grade1)) begin
      grade_of = 3'd0;
    end else if (s_ext < CW'(thr_grade2)) begin
      grade_of = 3'd1;
    end else if (s_ext < CW'(thr_grade3)) begin
      grade_of = 3'd2;
    end else if (s_ext < CW'(thr_grade4)) begin
      grade_of = 3'd3;
    end else begin
      grade_of = 3'd4;
    end
    if (s_ext < CW'(thr_critical)) begin
      band = '0;
    end else begin
      band = grade_of + 3'd1;
    end
  end

  // item update
  always_comb begin
    for (int i = 0; i < bgd_pkg::NUM_BANDS; i++) begin
      band_runs_next[i] = band_runs[i];
    end
    cur_grade_next         = cur_grade;
    chg_phase_next         = chg_phase;
    status_reg_next        = status_reg;
    plugged_while_off_next = plugged_while_off;
    low_flag_next          = low_flag;
    res                    = '0;

    case (req_type) inside
      bgd_pkg::REQ_REGRADE, bgd_pkg::REQ_INIT: begin
        band_runs_next[0] = '0;
        low_flag_next     = 1'b0;
        if (req_type == bgd_pkg::REQ_INIT && grade_of == '0) begin
          cur_grade_next = 3'd1;
        end else begin
          cur_grade_next = grade_of;
        end
      end
      bgd_pkg::REQ_SAMPLE: begin
        for (int i = 0; i < bgd_pkg::NUM_BANDS; i++) begin
          if (band == bgd_pkg::BAND_BITS'(i)) begin
            band_runs_next[i] = (band_runs[i] == RUN_MAX) ? band_runs[i] :
                                band_runs[i] + RUN_BITS'(1);
          end else begin
            band_runs_next[i] = '0;
          end
        end
        if (band == '0) begin
          band_runs_next[1] = run_limit;
        end
        for (int i = 0; i < bgd_pkg::NUM_BANDS; i++) begin
          if (band_runs_next[i] >= run_limit) begin
            band_runs_next[i] = run_limit;
            cur_grade_next = (i == 0) ? '0 : bgd_pkg::GRADE_BITS'(i - 1);
          end
        end

        if (!busy_pin && !full_pin) begin
          if (!plugged_while_off && !signed_on) begin
            res.restart            = 1'b1;
            plugged_while_off_next = 1'b1;
          end
          if (chg_phase != bgd_pkg::STAT_FULL) begin
            status_reg_next = bgd_pkg::STAT_CHARGING;
            chg_phase_next  = bgd_pkg::STAT_CHARGING;
            res.icon        = bgd_pkg::ICON_CHARGING;
          end else begin
            res.icon = bgd_pkg::ICON_FULL;
          end
        end else if (!busy_pin) begin
          chg_phase_next = bgd_pkg::STAT_FULL;
          if (!plugged_while_off && !signed_on) begin
            res.restart            = 1'b1;
            plugged_while_off_next = 1'b1;
          end
          res.icon        = bgd_pkg::ICON_FULL;
          status_reg_next = bgd_pkg::STAT_FULL;
        end else begin
          chg_phase_next  = bgd_pkg::STAT_NORMAL;
          status_reg_next = bgd_pkg::STAT_NORMAL;
          res.stop        = plugged_while_off & ~signed_on;
          plugged_while_off_next = 1'b0;
        end

        if (!low_flag && cur_grade_next == '0 && band_runs_next[0] >= run_limit) begin
          low_flag_next = 1'b1;
        end
        res.regrade = low_flag_next && status_reg_next != bgd_pkg::STAT_NORMAL;
        res.shut    = low_flag_next && status_reg_next == bgd_pkg::STAT_NORMAL &&
                      signed_on && !shutdown_pending;
      end
      default: begin
      end
    endcase

    res.grade  = cur_grade_next;
    res.status = status_reg_next;
    res.low    = low_flag_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_critical  <= bgd_pkg::THR_CRITICAL_RST;
      thr_grade1    <= bgd_pkg::THR_GRADE1_RST;
      thr_grade2    <= bgd_pkg::THR_GRADE2_RST;
      thr_grade3    <= bgd_pkg::THR_GRADE3_RST;
      thr_grade4    <= bgd_pkg::THR_GRADE4_RST;
      confirm_count <= bgd_pkg::CONFIRM_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bgd_pkg::REG_THR_CRITICAL:  thr_critical  <= cfg_data[bgd_pkg::THR_BITS-1:0];
        bgd_pkg::REG_THR_GRADE1:    thr_grade1    <= cfg_data[bgd_pkg::THR_BITS-1:0];
        bgd_pkg::REG_THR_GRADE2:    thr_grade2    <= cfg_data[bgd_pkg::THR_BITS-1:0];
        bgd_pkg::REG_THR_GRADE3:    thr_grade3    <= cfg_data[bgd_pkg::THR_BITS-1:0];
        bgd_pkg::REG_THR_GRADE4:    thr_grade4    <= cfg_data[bgd_pkg::THR_BITS-1:0];
        bgd_pkg::REG_CONFIRM_COUNT: confirm_count <= cfg_data[bgd_pkg::CONFIRM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bgd_pkg::NUM_BANDS; i++) begin
        band_runs[i] <= '0;
      end
      cur_grade         <= bgd_pkg::GRADE_RST;
      chg_phase         <= bgd_pkg::STAT_NORMAL;
      status_reg        <= bgd_pkg::STAT_NORMAL;
      plugged_while_off <= 1'b0;
      low_flag          <= 1'b0;
    end else if (in_accept) begin
      for (int i = 0; i < bgd_pkg::NUM_BANDS; i++) begin
        band_runs[i] <= band_runs_next[i];
      end
      cur_grade         <= cur_grade_next;
      chg_phase         <= chg_phase_next;
      status_reg        <= status_reg_next;
      plugged_while_off <= plugged_while_off_next;
      low_flag          <= low_flag_next;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end
      end else if (in_accept) begin
        if (!out_valid || out_take) begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end else begin
          skid_reg   <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign grade            = out_reg.grade;
  assign charge_status    = out_reg.status;
  assign charge_icon      = out_reg.icon;
  assign low_batt         = out_reg.low;
  assign regrade_request  = out_reg.regrade;
  assign shutdown_request = out_reg.shut;
  assign sensor_restart   = out_reg.restart;
  assign sensor_stop      = out_reg.stop;

endmodule

`default_nettype wire
